// ----- rtl/sobel_edge_magnitude_rgb_defines.svh -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: assertion macros
// Shared macros for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEDM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("sedm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SEDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("sedm assertion failed");

`endif

// ----- rtl/sedm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Word types, command struct and fixed constants of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sedm_pkg;

	// Item kinds.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Configuration register indexes and widths.
	localparam int CFG_DATA_BITS = 16;
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;
	localparam logic [10:0] WIDTH_RESET  = 11'd1024;
	localparam logic [15:0] HEIGHT_RESET = 16'd1024;

	// Virtual row counter width: rows run one past the frame during the drain.
	localparam int VROW_BITS = 17;

	// Sums of squares at or above this value round to 256 or more.
	localparam logic [20:0] SAT_LIMIT = 21'd65281;
	localparam logic [7:0]  PIX_MAX   = 8'd255;

	typedef struct packed {
		logic       kind;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} sedm_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} sedm_out_t;

	// Window taps forced to zero because they fall outside the frame.
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} sedm_mask_t;

	typedef struct packed {
		logic       load;
		logic       pix_zero;
		logic       ram_rd;
		logic       win_en;
		logic       grad_en;
		logic       sqr_en;
		logic       root_en;
		logic [2:0] root_bit;
		logic       rnd_en;
		logic       out_load;
		sedm_mask_t mask;
	} sedm_cmd_t;

endpackage

// ----- rtl/sedm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sedm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/sedm_datapath.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude datapath
// Line stores, 3x3 window, gradient sums and one square root unit per color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sedm_datapath import sedm_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  sedm_cmd_t     cmd,
	input  logic [AW-1:0] addr,
	input  sedm_in_t      in_data,
	output logic [7:0]    red_out,
	output logic [7:0]    green_out,
	output logic [7:0]    blue_out
);

	logic [23:0] pix_q;
	logic [23:0] up_rd;
	logic [23:0] lo_rd;
	logic [23:0] win_q [9];
	logic signed [10:0] gx_q [3];
	logic signed [10:0] gy_q [3];
	logic [20:0] sum_q [3];
	logic [7:0]  root_q [3];
	logic [7:0]  res_q [3];
	logic [7:0]  out_q [3];

	logic signed [11:0] gx_c [3];
	logic signed [11:0] gy_c [3];
	logic signed [21:0] sq_x [3];
	logic signed [21:0] sq_y [3];
	logic [7:0]  cand [3];
	logic [15:0] cand_sq [3];
	logic [15:0] root_sq [3];
	logic [20:0] rem_c [3];

	// Line stores: the upper one holds two rows back, the lower one row back.
	sedm_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (cmd.win_en),
		.waddr (addr),
		.wdata (lo_rd),
		.re    (cmd.ram_rd),
		.raddr (addr),
		.rdata (up_rd)
	);

	sedm_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (cmd.win_en),
		.waddr (addr),
		.wdata (pix_q),
		.re    (cmd.ram_rd),
		.raddr (addr),
		.rdata (lo_rd)
	);

	// Gradient sums with out-of-frame taps forced to zero, squares, root candidate and remainder.
	always_comb begin
		logic signed [11:0] t [9];
		for (int ch = 0; ch < 3; ch++) begin
			for (int k = 0; k < 9; k++) begin
				t[k] = $signed({4'b0000, win_q[k][(16 - 8 * ch) +: 8]});
				if ((k < 3 && cmd.mask.top) || (k > 5 && cmd.mask.bottom) ||
				    (k % 3 == 0 && cmd.mask.left) || (k % 3 == 2 && cmd.mask.right)) begin
					t[k] = '0;
				end
			end
			gx_c[ch] = t[2] - t[0] + 12'sd2 * (t[5] - t[3]) + t[8] - t[6];
			gy_c[ch] = t[6] - t[0] + 12'sd2 * (t[7] - t[1]) + t[8] - t[2];
			sq_x[ch] = gx_q[ch] * gx_q[ch];
			sq_y[ch] = gy_q[ch] * gy_q[ch];
			cand[ch] = root_q[ch] | (8'd1 << cmd.root_bit);
			cand_sq[ch] = cand[ch] * cand[ch];
			root_sq[ch] = root_q[ch] * root_q[ch];
			rem_c[ch] = sum_q[ch] - 21'(root_sq[ch]);
		end
	end

	// Window, arithmetic stages and output word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= cmd.pix_zero ? 24'd0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
		end
		if (cmd.win_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r * 3]     <= win_q[r * 3 + 1];
				win_q[r * 3 + 1] <= win_q[r * 3 + 2];
			end
			win_q[2] <= up_rd;
			win_q[5] <= lo_rd;
			win_q[8] <= pix_q;
		end
		for (int ch = 0; ch < 3; ch++) begin
			if (cmd.grad_en) begin
				gx_q[ch] <= gx_c[ch][10:0];
				gy_q[ch] <= gy_c[ch][10:0];
			end
			if (cmd.sqr_en) begin
				sum_q[ch]  <= 21'(sq_x[ch] + sq_y[ch]);
				root_q[ch] <= '0;
			end
			if (cmd.root_en && (21'(cand_sq[ch]) <= sum_q[ch])) begin
				root_q[ch] <= cand[ch];
			end
			if (cmd.rnd_en) begin
				if (sum_q[ch] >= SAT_LIMIT) begin
					res_q[ch] <= PIX_MAX;
				end else if (rem_c[ch] > 21'(root_q[ch])) begin
					res_q[ch] <= root_q[ch] + 8'd1;
				end else begin
					res_q[ch] <= root_q[ch];
				end
			end
			if (cmd.out_load) begin
				out_q[ch] <= res_q[ch];
			end
		end
	end

	assign red_out   = out_q[0];
	assign green_out = out_q[1];
	assign blue_out  = out_q[2];

endmodule

// ----- rtl/sedm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude controller
// Frame position, drain count, configuration and the sequencing state machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sedm_ctrl import sedm_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output sedm_cmd_t                cmd,
	output logic [AW-1:0]            addr,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_last
);

	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_WIN, S_GRAD, S_SQR, S_ROOT, S_RND, S_DONE
	} state_t;

	state_t          state_q;
	logic [10:0]     width_q;
	logic [15:0]     height_q;
	logic [15:0]     row_q;
	logic [AW-1:0]   col_q;
	logic [PW-1:0]   pend_q;
	logic [AW-1:0]   addr_q;
	sedm_mask_t      mask_q;
	logic            last_q;
	logic            emit_q;
	logic [2:0]      bit_q;
	logic            out_valid_q;
	logic            out_last_q;

	logic [EW-1:0]        eff_w;
	logic [15:0]          eff_h;
	logic                 is_pix;
	logic                 finished;
	logic                 push;
	logic                 accept;
	logic [PW-1:0]        drain_idx;
	logic                 wrap;
	logic [EW-1:0]        vcol;
	logic [VROW_BITS-1:0] vrow;
	logic                 emit;
	logic [VROW_BITS-1:0] orow;
	logic [EW-1:0]        ocol;
	sedm_mask_t           mask_c;
	logic                 last_c;
	logic                 out_free;

	// Effective frame size after clamping.
	always_comb begin
		if (width_q == 11'd0) begin
			eff_w = EW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(width_q);
		end
		eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	// Position of the item and of the result it produces. A drain tick acts
	// as a zero pixel at a virtual position past the end of the frame.
	always_comb begin
		is_pix    = (kind == KIND_PIXEL);
		finished  = (row_q == 16'd0) && (col_q == '0) && (pend_q != '0);
		push      = is_pix || finished;
		accept    = in_valid && in_ready;
		drain_idx = PW'(eff_w) + PW'(1) - pend_q;
		wrap      = (drain_idx == PW'(eff_w));
		if (is_pix) begin
			vcol = EW'(col_q);
			vrow = VROW_BITS'(row_q);
		end else begin
			vcol = wrap ? '0 : EW'(drain_idx);
			vrow = VROW_BITS'(eff_h) + VROW_BITS'(wrap);
		end
		emit = (vrow >= VROW_BITS'(2)) || ((vrow == VROW_BITS'(1)) && (vcol != '0));
		if (vcol != '0) begin
			orow = vrow - VROW_BITS'(1);
			ocol = vcol - EW'(1);
		end else begin
			orow = vrow - VROW_BITS'(2);
			ocol = eff_w - EW'(1);
		end
		mask_c.top    = (orow == '0);
		mask_c.bottom = ((VROW_BITS + 1)'(orow) + (VROW_BITS + 1)'(1)) >=
		                (VROW_BITS + 1)'(eff_h);
		mask_c.left   = (ocol == '0);
		mask_c.right  = (ocol + EW'(1)) >= eff_w;
		last_c = (orow == VROW_BITS'(eff_h) - VROW_BITS'(1)) && (ocol == eff_w - EW'(1));
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Commands to the datapath.
	always_comb begin
		cmd          = '0;
		cmd.load     = accept && push;
		cmd.pix_zero = !is_pix;
		cmd.ram_rd   = (state_q == S_READ);
		cmd.win_en   = (state_q == S_WIN);
		cmd.grad_en  = (state_q == S_GRAD);
		cmd.sqr_en   = (state_q == S_SQR);
		cmd.root_en  = (state_q == S_ROOT);
		cmd.root_bit = bit_q;
		cmd.rnd_en   = (state_q == S_RND);
		cmd.out_load = (state_q == S_DONE) && out_free;
		cmd.mask     = mask_q;
	end

	assign addr      = addr_q;
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;

	// State machine, frame position and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= WIDTH_RESET;
			height_q    <= HEIGHT_RESET;
			row_q       <= '0;
			col_q       <= '0;
			pend_q      <= '0;
			addr_q      <= '0;
			mask_q      <= '0;
			last_q      <= 1'b0;
			emit_q      <= 1'b0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// A register write restarts the frame.
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IDX_WIDTH:  width_q  <= cfg_data[10:0];
					CFG_IDX_HEIGHT: height_q <= cfg_data;
				endcase
				row_q  <= '0;
				col_q  <= '0;
				pend_q <= '0;
			end else if (accept && is_pix) begin
				if (EW'(col_q) == eff_w - EW'(1)) begin
					col_q <= '0;
					row_q <= (row_q == eff_h - 16'd1) ? 16'd0 : row_q + 16'd1;
				end else begin
					col_q <= col_q + AW'(1);
				end
				if ((EW'(col_q) == eff_w - EW'(1)) && (row_q == eff_h - 16'd1)) begin
					pend_q <= PW'(eff_w) + PW'(1);
				end else if (finished) begin
					pend_q <= '0;
				end
			end else if (accept && finished) begin
				pend_q <= pend_q - PW'(1);
			end

			// Output register handshake.
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_last_q  <= last_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && push) begin
						addr_q     <= vcol[AW-1:0];
						mask_q     <= mask_c;
						last_q     <= last_c && !is_pix;
						emit_q     <= emit;
						state_q    <= S_READ;
					end
				end
				S_READ: state_q <= S_WIN;
				S_WIN:  state_q <= emit_q ? S_GRAD : S_IDLE;
				S_GRAD: state_q <= S_SQR;
				S_SQR: begin
					bit_q   <= 3'd7;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0) begin
						state_q <= S_RND;
					end
				end
				S_RND:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/sobel_edge_magnitude_rgb.sv -----
// A word that yields a result passes the line store read, window shift, gradient,
// square, 8-step square root, rounding and output load before out_valid rises.
// A word is taken only in the idle state, not while an earlier one is in work.
// The next word is taken while a finished result waits in the output register.
// Reset clears position, drain count and output valid; size returns to 1024 x 1024.
// Line stores are not cleared; no clearing pass is run.
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel gradient magnitude per color with zero border.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_defines.svh"
module sobel_edge_magnitude_rgb import sedm_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  sedm_in_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output sedm_out_t                out_data,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	sedm_cmd_t     cmd;
	logic [AW-1:0] addr;

	// Sequencing and frame bookkeeping.
	sedm_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (in_data.kind),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.addr      (addr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_last  (out_data.frame_last)
	);

	// Line stores, window and arithmetic.
	sedm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.addr      (addr),
		.in_data   (in_data),
		.red_out   (out_data.red_out),
		.green_out (out_data.green_out),
		.blue_out  (out_data.blue_out)
	);

	// A result never overwrites one that has not been taken.
	`SEDM_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid || out_ready)
	// Datapath stages never run together.
	`SEDM_ASSERT_SAME(a_one_stage, clk, arst_n, 1'b1,
		$onehot0({cmd.ram_rd, cmd.win_en, cmd.grad_en, cmd.sqr_en, cmd.root_en, cmd.rnd_en}))
	// Line store read data is consumed in the cycle after the read.
	`SEDM_ASSERT_NEXT(a_read_then_shift, clk, arst_n, cmd.ram_rd, cmd.win_en)

endmodule
